// File: rtl/core/tdts_pkg.sv
// Shared types and constants for the tree dependency task scheduler.
// Holds the channel word layouts, command/status codes, datapath ops and status.
// No dependencies.
package tdts_pkg;

  localparam int IW     = 10;       // node id / depth width
  localparam int KW     = 2 * IW;   // heap key: {depth, id}
  localparam int CFG_AW = 3;        // two 32-bit registers
  localparam int CFG_DW = 32;

  // Register indexes (paddr[2])
  localparam logic REG_LEAF_COUNT = 1'b0;
  localparam logic REG_NODE_COUNT = 1'b1;

  // Commands
  localparam logic [1:0] CMD_LOAD     = 2'd0;
  localparam logic [1:0] CMD_START    = 2'd1;
  localparam logic [1:0] CMD_GET      = 2'd2;
  localparam logic [1:0] CMD_COMPLETE = 2'd3;

  // Result status
  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_ISSUED   = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FINISHED = 2'd3;

  typedef struct packed {
    logic [1:0]    command;
    logic [IW-1:0] node_index;
    logic [IW-1:0] left_child;
    logic [IW-1:0] right_child;
    logic          is_leaf;
  } tdts_in_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [IW-1:0] task_id;
    logic          task_is_leaf;
    logic [IW-1:0] first_child;
    logic [IW-1:0] second_child;
    logic          all_done;
  } tdts_out_t;

  // One entry of the node table
  typedef struct packed {
    logic          leaf;
    logic [IW-1:0] left;
    logic [IW-1:0] right;
  } tdts_node_t;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_LOAD, OP_CLR,
    OP_WALK_INIT, OP_WALK_RD, OP_WALK_L, OP_WALK_R, OP_DEC,
    OP_SCAN0, OP_LEAF_RD, OP_LEAF_KEY,
    OP_PUSH_INIT, OP_PUSH_RD, OP_PUSH_MOVE, OP_PUSH_WR,
    OP_PAR_RD, OP_PAR_L, OP_PAR_R,
    OP_GET_CHK, OP_POP_TOP, OP_POP_LAST, OP_POP_RD1, OP_POP_RD2,
    OP_POP_SEL, OP_POP_MOVE, OP_POP_WR, OP_POP_RES,
    OP_CMP_CHK, OP_CMP_P, OP_CMP_R, OP_EMIT
  } tdts_op_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic [1:0] cmd;
    logic clr_last;
    logic walk_done;
    logic scan_oob;
    logic leaf_done;
    logic par_done;
    logic heap_full;
    logic hi_zero;
    logic parent_ge;
    logic finished;
    logic heap_empty;
    logic c_ge_size;
    logic c1_lt_size;
    logic ck_le_last;
    logic cmp_oob;
    logic cmp_root;
    logic p_oob;
    logic rc_is1;
    logic out_free;
  } tdts_stat_t;

endpackage

// File: rtl/core/tdts_chan_if.sv
// Valid/ready channel carrying one word of a given payload type.
// Depends on nothing; payload types come from tdts_pkg at instantiation.
interface tdts_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/tdts_dpath.sv
// Datapath of the scheduler: node, depth, parent, ready and heap memories,
// loop counters, heap sift registers and the output word register. Uses tdts_pkg.
module tdts_dpath import tdts_pkg::*; #(
  parameter int MAX_NODES = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [IW-1:0] leaf_count_i,
  input  logic [IW-1:0] node_count_i,
  input  tdts_in_t      in_data_i,
  input  tdts_op_t      op_i,
  output tdts_stat_t    stat_o,
  output logic          out_valid_o,
  output tdts_out_t     out_data_o,
  input  logic          out_ready_i
);

  localparam int AW = $clog2(MAX_NODES);
  localparam int HW = $clog2(MAX_NODES + 1);
  localparam int SW = ((AW > IW) ? AW : IW) + 2;

  // Memories
  tdts_node_t    node_mem   [MAX_NODES];
  logic [IW-1:0] depth_mem  [MAX_NODES];
  logic [IW-1:0] parent_mem [MAX_NODES];
  logic [1:0]    ready_mem  [MAX_NODES];
  logic [KW-1:0] heap_mem   [MAX_NODES];

  tdts_node_t    node_q;
  logic [IW-1:0] depth_q, parent_q;
  logic [1:0]    ready_q;
  logic [KW-1:0] heap_q;

  // Registers
  logic [1:0]    cmd_r, cmd_nxt;
  logic [IW-1:0] idx_r, idx_nxt, lch_r, lch_nxt, rch_r, rch_nxt;
  logic          leaf_r, leaf_nxt;
  logic [SW-1:0] scan_r, scan_nxt;
  logic [HW-1:0] heap_size_r, heap_size_nxt;
  logic          finished_r, finished_nxt;
  logic [AW-1:0] hi_r, hi_nxt, hc_r, hc_nxt;
  logic [KW-1:0] hkey_r, hkey_nxt, ck_r, ck_nxt, top_r, top_nxt;
  logic [IW-1:0] pn_r, pn_nxt, dn_r, dn_nxt;
  logic [1:0]    rs_status_r, rs_status_nxt;
  logic [IW-1:0] rs_tid_r, rs_tid_nxt, rs_c1_r, rs_c1_nxt, rs_c2_r, rs_c2_nxt;
  logic          rs_leaf_r, rs_leaf_nxt;
  logic          out_valid_r, out_valid_nxt;
  tdts_out_t     out_r, out_nxt;

  // Memory port controls
  logic          node_we, node_re, depth_we, depth_re, par_we, par_re;
  logic          rdy_we, rdy_re, heap_we, heap_re;
  logic [AW-1:0] node_wa, node_ra, depth_wa, depth_ra, par_wa, par_ra;
  logic [AW-1:0] rdy_wa, rdy_ra, heap_wa, heap_ra;
  logic [IW-1:0] depth_wd, par_wd;
  logic [1:0]    rdy_wd;
  logic [KW-1:0] heap_wd;

  // Derived values
  logic [IW-1:0] root;
  logic [AW:0]   cidx;
  logic [AW-1:0] pidx;
  logic [IW-1:0] depth_inc;
  logic          idx_ok, l_ok, r_ok, out_free;

  assign root      = (node_count_i == '0) ? '0 : node_count_i - IW'(1);
  assign cidx      = {hi_r, 1'b1};
  assign pidx      = AW'((hi_r - AW'(1)) >> 1);
  assign depth_inc = depth_q + IW'(1);
  assign idx_ok    = 32'(idx_r) < 32'(MAX_NODES);
  assign l_ok      = 32'(node_q.left) < 32'(MAX_NODES);
  assign r_ok      = 32'(node_q.right) < 32'(MAX_NODES);
  assign out_free  = !out_valid_r || out_ready_i;

  // Status toward the controller
  always_comb begin
    stat_o.cmd        = cmd_r;
    stat_o.clr_last   = 32'(scan_r) == 32'(MAX_NODES - 1);
    stat_o.walk_done  = $signed(scan_r) < $signed(SW'(leaf_count_i));
    stat_o.scan_oob   = 32'(scan_r) >= 32'(MAX_NODES);
    stat_o.leaf_done  = (32'(scan_r) >= 32'(leaf_count_i)) ||
                        (32'(scan_r) >= 32'(MAX_NODES));
    stat_o.par_done   = (32'(scan_r) > 32'(root)) || (32'(scan_r) >= 32'(MAX_NODES));
    stat_o.heap_full  = 32'(heap_size_r) >= 32'(MAX_NODES);
    stat_o.hi_zero    = hi_r == '0;
    stat_o.parent_ge  = heap_q >= hkey_r;
    stat_o.finished   = finished_r;
    stat_o.heap_empty = heap_size_r == '0;
    stat_o.c_ge_size  = 32'(cidx) >= 32'(heap_size_r);
    stat_o.c1_lt_size = (32'(cidx) + 32'd1) < 32'(heap_size_r);
    stat_o.ck_le_last = ck_r <= hkey_r;
    stat_o.cmp_oob    = (idx_r >= node_count_i) || !idx_ok;
    stat_o.cmp_root   = idx_r == root;
    stat_o.p_oob      = 32'(parent_q) >= 32'(MAX_NODES);
    stat_o.rc_is1     = ready_q == 2'd1;
    stat_o.out_free   = out_free;
  end

  // Memory port decode
  always_comb begin
    node_we  = 1'b0; node_wa  = AW'(idx_r);   node_re  = 1'b0; node_ra  = AW'(scan_r);
    depth_we = 1'b0; depth_wa = AW'(scan_r);  depth_re = 1'b0; depth_ra = AW'(scan_r);
    par_we   = 1'b0; par_wa   = AW'(scan_r);  par_re   = 1'b0; par_ra   = AW'(idx_r);
    rdy_we   = 1'b0; rdy_wa   = AW'(scan_r);  rdy_re   = 1'b0; rdy_ra   = AW'(parent_q);
    heap_we  = 1'b0; heap_wa  = hi_r;         heap_re  = 1'b0; heap_ra  = pidx;
    depth_wd = '0;
    par_wd   = '0;
    rdy_wd   = '0;
    heap_wd  = hkey_r;
    case (op_i)
      OP_LOAD: node_we = idx_ok;
      OP_CLR: begin
        depth_we = 1'b1;
        par_we   = 1'b1;
        rdy_we   = 1'b1;
      end
      OP_WALK_RD: begin
        node_re  = 1'b1;
        depth_re = 1'b1;
      end
      OP_WALK_L: begin
        depth_we = !node_q.leaf && l_ok;
        depth_wa = AW'(node_q.left);
        depth_wd = depth_inc;
      end
      OP_WALK_R: begin
        depth_we = !node_q.leaf && r_ok;
        depth_wa = AW'(node_q.right);
        depth_wd = depth_inc;
      end
      OP_LEAF_RD: depth_re = 1'b1;
      OP_PUSH_RD: heap_re = 1'b1;
      OP_PUSH_MOVE: begin
        heap_we = !(heap_q >= hkey_r);
        heap_wd = heap_q;
      end
      OP_PUSH_WR: heap_we = 1'b1;
      OP_PAR_RD: node_re = 1'b1;
      OP_PAR_L: begin
        par_we = !node_q.leaf && l_ok;
        par_wa = AW'(node_q.left);
        par_wd = IW'(scan_r);
      end
      OP_PAR_R: begin
        par_we = !node_q.leaf && r_ok;
        par_wa = AW'(node_q.right);
        par_wd = IW'(scan_r);
      end
      OP_GET_CHK: begin
        heap_re = 1'b1;
        heap_ra = '0;
      end
      OP_POP_TOP: begin
        heap_re = 1'b1;
        heap_ra = AW'(heap_size_r - HW'(1));
      end
      OP_POP_RD1: begin
        heap_re = 1'b1;
        heap_ra = AW'(cidx);
      end
      OP_POP_RD2: begin
        heap_re = 1'b1;
        heap_ra = AW'(cidx + (AW+1)'(1));
      end
      OP_POP_MOVE: begin
        heap_we = !(ck_r <= hkey_r);
        heap_wd = ck_r;
      end
      OP_POP_WR: begin
        heap_we = 1'b1;
        node_re = 1'b1;
        node_ra = AW'(top_r[IW-1:0]);
      end
      OP_CMP_CHK: begin
        par_re   = 1'b1;
        depth_re = 1'b1;
        depth_ra = AW'(idx_r);
      end
      OP_CMP_P: rdy_re = 1'b1;
      OP_CMP_R: begin
        rdy_we = ready_q != 2'd3;
        rdy_wa = AW'(pn_r);
        rdy_wd = ready_q + 2'd1;
      end
      default: ;
    endcase
  end

  // Memories, registered reads
  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_wa] <= '{leaf: leaf_r, left: lch_r, right: rch_r};
    if (node_re) node_q <= node_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (depth_we) depth_mem[depth_wa] <= depth_wd;
    if (depth_re) depth_q <= depth_mem[depth_ra];
  end

  always_ff @(posedge clk) begin
    if (par_we) parent_mem[par_wa] <= par_wd;
    if (par_re) parent_q <= parent_mem[par_ra];
  end

  always_ff @(posedge clk) begin
    if (rdy_we) ready_mem[rdy_wa] <= rdy_wd;
    if (rdy_re) ready_q <= ready_mem[rdy_ra];
  end

  always_ff @(posedge clk) begin
    if (heap_we) heap_mem[heap_wa] <= heap_wd;
    if (heap_re) heap_q <= heap_mem[heap_ra];
  end

  // Register next-state logic
  always_comb begin
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    lch_nxt       = lch_r;
    rch_nxt       = rch_r;
    leaf_nxt      = leaf_r;
    scan_nxt      = scan_r;
    heap_size_nxt = heap_size_r;
    finished_nxt  = finished_r;
    hi_nxt        = hi_r;
    hc_nxt        = hc_r;
    hkey_nxt      = hkey_r;
    ck_nxt        = ck_r;
    top_nxt       = top_r;
    pn_nxt        = pn_r;
    dn_nxt        = dn_r;
    rs_status_nxt = rs_status_r;
    rs_tid_nxt    = rs_tid_r;
    rs_leaf_nxt   = rs_leaf_r;
    rs_c1_nxt     = rs_c1_r;
    rs_c2_nxt     = rs_c2_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready_i;
    case (op_i)
      OP_CAPTURE: begin
        cmd_nxt       = in_data_i.command;
        idx_nxt       = in_data_i.node_index;
        lch_nxt       = in_data_i.left_child;
        rch_nxt       = in_data_i.right_child;
        leaf_nxt      = in_data_i.is_leaf;
        scan_nxt      = '0;
        rs_status_nxt = ST_ACCEPTED;
        rs_tid_nxt    = '0;
        rs_leaf_nxt   = 1'b0;
        rs_c1_nxt     = '0;
        rs_c2_nxt     = '0;
      end
      OP_CLR: begin
        scan_nxt      = scan_r + SW'(1);
        heap_size_nxt = '0;
        finished_nxt  = 1'b0;
      end
      OP_WALK_INIT: scan_nxt = SW'(root);
      OP_DEC:       scan_nxt = scan_r - SW'(1);
      OP_SCAN0:     scan_nxt = '0;
      OP_LEAF_KEY: begin
        hkey_nxt = {depth_q, IW'(scan_r)};
        scan_nxt = scan_r + SW'(1);
      end
      OP_PAR_R: scan_nxt = scan_r + SW'(1);
      OP_PUSH_INIT: begin
        if (!(32'(heap_size_r) >= 32'(MAX_NODES))) begin
          hi_nxt        = AW'(heap_size_r);
          heap_size_nxt = heap_size_r + HW'(1);
        end
      end
      OP_PUSH_MOVE: if (!(heap_q >= hkey_r)) hi_nxt = pidx;
      OP_GET_CHK: begin
        if (finished_r) begin
          rs_status_nxt = ST_FINISHED;
        end else if (heap_size_r == '0) begin
          rs_status_nxt = ST_EMPTY;
        end
      end
      OP_POP_TOP: begin
        top_nxt       = heap_q;
        heap_size_nxt = heap_size_r - HW'(1);
      end
      OP_POP_LAST: begin
        hkey_nxt = heap_q;
        hi_nxt   = '0;
      end
      OP_POP_RD2: begin
        ck_nxt = heap_q;
        hc_nxt = AW'(cidx);
      end
      OP_POP_SEL: begin
        if (heap_q > ck_r) begin
          ck_nxt = heap_q;
          hc_nxt = AW'(cidx + (AW+1)'(1));
        end
      end
      OP_POP_MOVE: if (!(ck_r <= hkey_r)) hi_nxt = hc_r;
      OP_POP_RES: begin
        rs_status_nxt = ST_ISSUED;
        rs_tid_nxt    = top_r[IW-1:0];
        if (32'(top_r[IW-1:0]) < 32'(MAX_NODES)) begin
          if (node_q.leaf) begin
            rs_leaf_nxt = 1'b1;
          end else begin
            rs_c1_nxt = node_q.left;
            rs_c2_nxt = node_q.right;
          end
        end
      end
      OP_CMP_CHK: begin
        if (!((idx_r >= node_count_i) || !idx_ok) && (idx_r == root)) finished_nxt = 1'b1;
      end
      OP_CMP_P: begin
        pn_nxt = parent_q;
        dn_nxt = depth_q;
      end
      OP_CMP_R: hkey_nxt = {dn_r, pn_r};
      OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.status       = rs_status_r;
          out_nxt.task_id      = rs_tid_r;
          out_nxt.task_is_leaf = rs_leaf_r;
          out_nxt.first_child  = rs_c1_r;
          out_nxt.second_child = rs_c2_r;
          out_nxt.all_done     = finished_r;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r      <= '0;
      heap_size_r <= '0;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      scan_r      <= scan_nxt;
      heap_size_r <= heap_size_nxt;
      finished_r  <= finished_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    idx_r       <= idx_nxt;
    lch_r       <= lch_nxt;
    rch_r       <= rch_nxt;
    leaf_r      <= leaf_nxt;
    hi_r        <= hi_nxt;
    hc_r        <= hc_nxt;
    hkey_r      <= hkey_nxt;
    ck_r        <= ck_nxt;
    top_r       <= top_nxt;
    pn_r        <= pn_nxt;
    dn_r        <= dn_nxt;
    rs_status_r <= rs_status_nxt;
    rs_tid_r    <= rs_tid_nxt;
    rs_leaf_r   <= rs_leaf_nxt;
    rs_c1_r     <= rs_c1_nxt;
    rs_c2_r     <= rs_c2_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_r;

endmodule

// File: rtl/core/tdts_ctrl.sv
// Controller state machine of the scheduler: sequences each command as
// datapath operations and waits on datapath status. Uses tdts_pkg.
module tdts_ctrl import tdts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  tdts_stat_t stat_i,
  output tdts_op_t   op_o
);

  localparam logic [5:0] S_RCLR      = 6'd0;
  localparam logic [5:0] S_IDLE      = 6'd1;
  localparam logic [5:0] S_DISP      = 6'd2;
  localparam logic [5:0] S_LOAD      = 6'd3;
  localparam logic [5:0] S_CLR       = 6'd4;
  localparam logic [5:0] S_WALK_INIT = 6'd5;
  localparam logic [5:0] S_WALK_CHK  = 6'd6;
  localparam logic [5:0] S_WALK_L    = 6'd7;
  localparam logic [5:0] S_WALK_R    = 6'd8;
  localparam logic [5:0] S_WALK_NEXT = 6'd9;
  localparam logic [5:0] S_LEAF_INIT = 6'd10;
  localparam logic [5:0] S_LEAF_CHK  = 6'd11;
  localparam logic [5:0] S_LEAF_KEY  = 6'd12;
  localparam logic [5:0] S_PUSH      = 6'd13;
  localparam logic [5:0] S_PUSH_CHK  = 6'd14;
  localparam logic [5:0] S_PUSH_CMP  = 6'd15;
  localparam logic [5:0] S_PUSH_WR   = 6'd16;
  localparam logic [5:0] S_PAR_INIT  = 6'd17;
  localparam logic [5:0] S_PAR_CHK   = 6'd18;
  localparam logic [5:0] S_PAR_L     = 6'd19;
  localparam logic [5:0] S_PAR_R     = 6'd20;
  localparam logic [5:0] S_GET       = 6'd21;
  localparam logic [5:0] S_POP_TOP   = 6'd22;
  localparam logic [5:0] S_POP_LAST  = 6'd23;
  localparam logic [5:0] S_POP_CHK   = 6'd24;
  localparam logic [5:0] S_POP_RD2   = 6'd25;
  localparam logic [5:0] S_POP_SEL   = 6'd26;
  localparam logic [5:0] S_POP_CMP   = 6'd27;
  localparam logic [5:0] S_POP_WR    = 6'd28;
  localparam logic [5:0] S_POP_NODE  = 6'd29;
  localparam logic [5:0] S_CMP0      = 6'd30;
  localparam logic [5:0] S_CMP1      = 6'd31;
  localparam logic [5:0] S_CMP2      = 6'd32;
  localparam logic [5:0] S_OUT       = 6'd33;

  logic [5:0] state_r, state_nxt;
  logic       ret_out_r, ret_out_nxt;  // push returns to output (else leaf loop)
  logic [5:0] push_ret;

  assign push_ret = ret_out_r ? S_OUT : S_LEAF_CHK;

  // Next state and operation
  always_comb begin
    state_nxt   = state_r;
    ret_out_nxt = ret_out_r;
    op_o        = OP_NONE;
    in_ready_o  = 1'b0;
    unique case (state_r)
      S_RCLR: begin
        op_o = OP_CLR;
        if (stat_i.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o      = OP_CAPTURE;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat_i.cmd)
          CMD_LOAD:     state_nxt = S_LOAD;
          CMD_START:    state_nxt = S_CLR;
          CMD_GET:      state_nxt = S_GET;
          CMD_COMPLETE: state_nxt = S_CMP0;
          default:      state_nxt = S_OUT;
        endcase
      end
      S_LOAD: begin
        op_o      = OP_LOAD;
        state_nxt = S_OUT;
      end
      // start: clear, depth walk, leaf pushes, parent links
      S_CLR: begin
        op_o = OP_CLR;
        if (stat_i.clr_last) state_nxt = S_WALK_INIT;
      end
      S_WALK_INIT: begin
        op_o      = OP_WALK_INIT;
        state_nxt = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        op_o = OP_WALK_RD;
        if (stat_i.walk_done)     state_nxt = S_LEAF_INIT;
        else if (stat_i.scan_oob) state_nxt = S_WALK_NEXT;
        else                      state_nxt = S_WALK_L;
      end
      S_WALK_L: begin
        op_o      = OP_WALK_L;
        state_nxt = S_WALK_R;
      end
      S_WALK_R: begin
        op_o      = OP_WALK_R;
        state_nxt = S_WALK_NEXT;
      end
      S_WALK_NEXT: begin
        op_o      = OP_DEC;
        state_nxt = S_WALK_CHK;
      end
      S_LEAF_INIT: begin
        op_o      = OP_SCAN0;
        state_nxt = S_LEAF_CHK;
      end
      S_LEAF_CHK: begin
        op_o      = OP_LEAF_RD;
        state_nxt = stat_i.leaf_done ? S_PAR_INIT : S_LEAF_KEY;
      end
      S_LEAF_KEY: begin
        op_o        = OP_LEAF_KEY;
        ret_out_nxt = 1'b0;
        state_nxt   = S_PUSH;
      end
      // heap push: sift up one level per compare
      S_PUSH: begin
        op_o      = OP_PUSH_INIT;
        state_nxt = stat_i.heap_full ? push_ret : S_PUSH_CHK;
      end
      S_PUSH_CHK: begin
        op_o      = OP_PUSH_RD;
        state_nxt = stat_i.hi_zero ? S_PUSH_WR : S_PUSH_CMP;
      end
      S_PUSH_CMP: begin
        op_o      = OP_PUSH_MOVE;
        state_nxt = stat_i.parent_ge ? S_PUSH_WR : S_PUSH_CHK;
      end
      S_PUSH_WR: begin
        op_o      = OP_PUSH_WR;
        state_nxt = push_ret;
      end
      S_PAR_INIT: begin
        op_o      = OP_SCAN0;
        state_nxt = S_PAR_CHK;
      end
      S_PAR_CHK: begin
        op_o      = OP_PAR_RD;
        state_nxt = stat_i.par_done ? S_OUT : S_PAR_L;
      end
      S_PAR_L: begin
        op_o      = OP_PAR_L;
        state_nxt = S_PAR_R;
      end
      S_PAR_R: begin
        op_o      = OP_PAR_R;
        state_nxt = S_PAR_CHK;
      end
      // get task: pop with sift down
      S_GET: begin
        op_o = OP_GET_CHK;
        if (stat_i.finished || stat_i.heap_empty) state_nxt = S_OUT;
        else                                     state_nxt = S_POP_TOP;
      end
      S_POP_TOP: begin
        op_o      = OP_POP_TOP;
        state_nxt = S_POP_LAST;
      end
      S_POP_LAST: begin
        op_o      = OP_POP_LAST;
        state_nxt = S_POP_CHK;
      end
      S_POP_CHK: begin
        op_o      = OP_POP_RD1;
        state_nxt = stat_i.c_ge_size ? S_POP_WR : S_POP_RD2;
      end
      S_POP_RD2: begin
        op_o      = OP_POP_RD2;
        state_nxt = stat_i.c1_lt_size ? S_POP_SEL : S_POP_CMP;
      end
      S_POP_SEL: begin
        op_o      = OP_POP_SEL;
        state_nxt = S_POP_CMP;
      end
      S_POP_CMP: begin
        op_o      = OP_POP_MOVE;
        state_nxt = stat_i.ck_le_last ? S_POP_WR : S_POP_CHK;
      end
      S_POP_WR: begin
        op_o      = OP_POP_WR;
        state_nxt = S_POP_NODE;
      end
      S_POP_NODE: begin
        op_o      = OP_POP_RES;
        state_nxt = S_OUT;
      end
      // complete task
      S_CMP0: begin
        op_o      = OP_CMP_CHK;
        state_nxt = (stat_i.cmp_oob || stat_i.cmp_root) ? S_OUT : S_CMP1;
      end
      S_CMP1: begin
        op_o      = OP_CMP_P;
        state_nxt = stat_i.p_oob ? S_OUT : S_CMP2;
      end
      S_CMP2: begin
        op_o = OP_CMP_R;
        if (stat_i.rc_is1) begin
          ret_out_nxt = 1'b1;
          state_nxt   = S_PUSH;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        op_o = OP_EMIT;
        if (stat_i.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_RCLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_RCLR;
      ret_out_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ret_out_r <= ret_out_nxt;
    end
  end

endmodule

// File: rtl/core/tree_dependency_task_scheduler_core.sv
// Top level of the tree dependency task scheduler: config registers (APB),
// controller and datapath. Uses tdts_pkg, tdts_chan_if, tdts_ctrl, tdts_dpath.
//
// One command word is taken at a time and answered by exactly one result word.
// After reset the block clears its depth, parent and ready tables before
// it takes the first word. Start runs a clearing pass, then the depth walk
// over the internal nodes, one heap push per leaf and the parent links. A
// push climbs and a pop descends the heap one level per compare; both are
// bound by the single heap memory read port (one read per cycle). Complete
// adds a push when a parent becomes ready. The result register frees the
// input side: the next word is taken while the previous result still waits.
module tree_dependency_task_scheduler_core import tdts_pkg::*; #(
  parameter int MAX_NODES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  tdts_chan_if.sink         in_item,
  tdts_chan_if.source       out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic [IW-1:0] leaf_count_r, leaf_count_nxt;
  logic [IW-1:0] node_count_r, node_count_nxt;
  tdts_op_t      op;
  tdts_stat_t    stat;

  // Config register writes
  always_comb begin
    leaf_count_nxt = leaf_count_r;
    node_count_nxt = node_count_r;
    if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_LEAF_COUNT: leaf_count_nxt = pwdata[IW-1:0];
        REG_NODE_COUNT: node_count_nxt = pwdata[IW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leaf_count_r <= IW'(1);
      node_count_r <= IW'(1);
    end else begin
      leaf_count_r <= leaf_count_nxt;
      node_count_r <= node_count_nxt;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NODE_COUNT) ? CFG_DW'(node_count_r)
                                               : CFG_DW'(leaf_count_r);

  tdts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_item.valid),
    .in_ready_o (in_item.ready),
    .stat_i     (stat),
    .op_o       (op)
  );

  tdts_dpath #(
    .MAX_NODES (MAX_NODES)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .leaf_count_i (leaf_count_r),
    .node_count_i (node_count_r),
    .in_data_i    (in_item.data),
    .op_i         (op),
    .stat_o       (stat),
    .out_valid_o  (out_item.valid),
    .out_data_o   (out_item.data),
    .out_ready_i  (out_item.ready)
  );

endmodule

// File: tb/sv/tb_tree_dependency_task_scheduler_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for tree_dependency_task_scheduler_core: builds merge trees,
// runs start / get / complete traffic and checks every result word against a predictor.
// Depends on tdts_pkg, tdts_chan_if and the core RTL.

import tdts_pkg::*;

// Predictor of the scheduler plus the queue of result words still owed
class sched_scoreboard;
  logic [IW-1:0] left_tbl[1024];
  logic [IW-1:0] right_tbl[1024];
  logic          leaf_tbl[1024];
  logic [IW-1:0] depth_tbl[1024];
  logic [IW-1:0] parent_tbl[1024];
  logic [1:0]    ready_cnt[1024];
  logic [KW-1:0] heap[1024];
  int            heap_size;
  bit            finished;
  int            leaf_count;
  int            node_count;
  tdts_out_t     pending_results[$];
  int            issued_ids[$];
  int            accepted;
  int            errors;

  function new();
    heap_size = 0;
    finished = 0;
    leaf_count = 1;
    node_count = 1;
    accepted = 0;
    errors = 0;
    for (int i = 0; i < 1024; i++) begin
      depth_tbl[i] = '0;
      parent_tbl[i] = '0;
      ready_cnt[i] = '0;
    end
  endfunction

  function void write_reg(logic idx, int val);
    if (idx == REG_LEAF_COUNT) leaf_count = val & 1023;
    else node_count = val & 1023;
  endfunction

  function int root_id();
    return (node_count == 0) ? 0 : node_count - 1;
  endfunction

  function void heap_insert(logic [KW-1:0] key);
    int i, p;
    if (heap_size >= 1024) return;
    i = heap_size;
    heap_size++;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (heap[p] >= key) break;
      heap[i] = heap[p];
      i = p;
    end
    heap[i] = key;
  endfunction

  function logic [KW-1:0] heap_take();
    logic [KW-1:0] top, last;
    int i, c;
    top = heap[0];
    heap_size--;
    last = heap[heap_size];
    i = 0;
    while (1) begin
      c = 2 * i + 1;
      if (c >= heap_size) break;
      if (c + 1 < heap_size && heap[c+1] > heap[c]) c++;
      if (heap[c] <= last) break;
      heap[i] = heap[c];
      i = c;
    end
    heap[i] = last;
    return top;
  endfunction

  function void start_schedule();
    int root;
    logic [IW-1:0] d;
    root = root_id();
    for (int i = 0; i < 1024; i++) begin
      depth_tbl[i] = '0;
      parent_tbl[i] = '0;
      ready_cnt[i] = '0;
    end
    heap_size = 0;
    finished = 0;
    // depth walk from the root down to the first internal index
    for (int i = root; i >= leaf_count; i--) begin
      if (!leaf_tbl[i]) begin
        d = depth_tbl[i] + 1'b1;
        depth_tbl[left_tbl[i]] = d;
        depth_tbl[right_tbl[i]] = d;
      end
    end
    for (int u = 0; u < leaf_count; u++) heap_insert({depth_tbl[u], IW'(u)});
    for (int u = 0; u <= root; u++) begin
      if (!leaf_tbl[u]) begin
        parent_tbl[left_tbl[u]] = IW'(u);
        parent_tbl[right_tbl[u]] = IW'(u);
      end
    end
  endfunction

  function void complete_node(int n);
    logic [IW-1:0] p;
    if (n >= node_count) return;
    if (n == root_id()) begin
      finished = 1;
      return;
    end
    p = parent_tbl[n];
    if (ready_cnt[p] < 3) begin
      ready_cnt[p]++;
      if (ready_cnt[p] == 2) heap_insert({depth_tbl[n], p});
    end
  endfunction

  // Accepted command word: update state, queue the expected result
  function void note_command(tdts_in_t w);
    tdts_out_t r;
    logic [KW-1:0] key;
    r = '0;
    r.status = ST_ACCEPTED;
    accepted++;
    case (w.command)
      CMD_LOAD: begin
        left_tbl[w.node_index] = w.left_child;
        right_tbl[w.node_index] = w.right_child;
        leaf_tbl[w.node_index] = w.is_leaf;
      end
      CMD_START: start_schedule();
      CMD_GET: begin
        if (finished) r.status = ST_FINISHED;
        else if (heap_size == 0) r.status = ST_EMPTY;
        else begin
          key = heap_take();
          r.status = ST_ISSUED;
          r.task_id = key[IW-1:0];
          if (leaf_tbl[r.task_id]) r.task_is_leaf = 1'b1;
          else begin
            r.first_child = left_tbl[r.task_id];
            r.second_child = right_tbl[r.task_id];
          end
          issued_ids = {issued_ids, int'(r.task_id)};
        end
      end
      default: complete_node(w.node_index);
    endcase
    r.all_done = finished;
    pending_results = {pending_results, r};
  endfunction

  function void check_result(tdts_out_t got);
    tdts_out_t exp;
    if (pending_results.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result word %h", got);
      return;
    end
    exp = pending_results.pop_front();
    if (got.status !== exp.status || got.task_id !== exp.task_id ||
        got.task_is_leaf !== exp.task_is_leaf || got.first_child !== exp.first_child ||
        got.second_child !== exp.second_child || got.all_done !== exp.all_done) begin
      errors++;
      if (errors <= 10)
        $display("result mismatch: exp st=%0d id=%0d lf=%0d c=%0d/%0d dn=%0d,",
                 exp.status, exp.task_id, exp.task_is_leaf, exp.first_child,
                 exp.second_child, exp.all_done,
                 " got st=%0d id=%0d lf=%0d c=%0d/%0d dn=%0d",
                 got.status, got.task_id, got.task_is_leaf, got.first_child,
                 got.second_child, got.all_done);
    end
  endfunction
endclass

module tb_tree_dependency_task_scheduler_core;
  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  tdts_chan_if #(.payload_t(tdts_in_t))  in_ch();
  tdts_chan_if #(.payload_t(tdts_out_t)) out_ch();

  tree_dependency_task_scheduler_core uut (
    .clk(clk), .rst_n(rst_n), .in_item(in_ch), .out_item(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sched_scoreboard sb = new();
  int idle_mode;     // 0 none, 1 sender, 2 receiver, 3 both
  int hold_cycles;   // long receiver hold-off

  always #5 clk = ~clk;

  // Result side: check accepted words, stall per idle mode
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_mode == 2) out_ch.ready <= ($urandom_range(0, 99) >= 57);
    else if (idle_mode == 3) out_ch.ready <= ($urandom_range(0, 99) >= 25);
    else out_ch.ready <= 1'b1;
  end

  task automatic send_word(tdts_in_t w);
    while ((idle_mode == 1 && $urandom_range(0, 99) < 57) ||
           (idle_mode == 3 && $urandom_range(0, 99) < 25)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_command(w);
  endtask

  task automatic send_cmd(logic [1:0] cmd, int idx);
    tdts_in_t w;
    w = '0;
    w.command = cmd;
    w.node_index = IW'(idx);
    send_word(w);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // One tree: configure, load every node that can be read, start, then
  // get / complete traffic driven by the tasks issued so far.
  task automatic run_tree(int lc, int nc, bit well_formed, int steps, int mode);
    int pool[$];
    int n_load, k, a, b, r;
    tdts_in_t w;
    drain();
    write_reg(REG_LEAF_COUNT, lc);
    write_reg(REG_NODE_COUNT, nc);
    idle_mode = mode;
    sb.issued_ids.delete();
    n_load = (lc > nc) ? lc : ((nc == 0) ? 1 : nc);
    for (int i = 0; i < lc; i++) pool = {pool, i};
    for (int i = 0; i < n_load; i++) begin
      w = '0;
      w.command = CMD_LOAD;
      w.node_index = IW'(i);
      if (well_formed) begin
        if (i < lc || pool.size() < 2) w.is_leaf = (i < lc);
        else begin
          k = $urandom_range(0, pool.size() - 1);
          a = pool[k];
          pool.delete(k);
          k = $urandom_range(0, pool.size() - 1);
          b = pool[k];
          pool.delete(k);
          pool = {pool, i};
          w.left_child = IW'(a);
          w.right_child = IW'(b);
        end
      end else begin
        w.is_leaf = ($urandom_range(0, 3) == 0);
        w.left_child = IW'($urandom_range(0, 1) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, n_load - 1));
        w.right_child = IW'($urandom_range(0, 1) ? $urandom_range(0, 1023)
                                                 : $urandom_range(0, n_load - 1));
      end
      send_word(w);
    end
    send_cmd(CMD_START, $urandom_range(0, 1023));
    for (int s = 0; s < steps; s++) begin
      r = $urandom_range(0, 99);
      if (sb.finished && r < 70) break;
      if (sb.issued_ids.size() != 0 && r < 45) begin
        k = $urandom_range(0, sb.issued_ids.size() - 1);
        a = sb.issued_ids[k];
        sb.issued_ids.delete(k);
        send_cmd(CMD_COMPLETE, a);
      end else if (r < 50) send_cmd(CMD_COMPLETE, $urandom_range(0, 1023));
      else if (r < 52) send_cmd(CMD_START, 0);
      else send_cmd(CMD_GET, 0);
    end
  endtask

  // Stimulus
  initial begin
    int lc, nc, phase;
    bit wf;
    clk = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    idle_mode = 0;
    hold_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty get, single leaf root, zero node count, small trees
    send_cmd(CMD_GET, 0);
    run_tree(1, 1, 1, 5, 0);
    run_tree(1, 0, 0, 5, 0);
    run_tree(3, 5, 1, 14, 0);
    run_tree(2, 3, 0, 10, 0);
    run_tree(64, 127, 1, 60, 0);

    // random trees, mostly well-formed, rotating idle modes
    phase = 0;
    while (sb.accepted < 680) begin
      lc = $urandom_range(1, 12);
      wf = ($urandom_range(0, 3) != 0);
      nc = wf ? 2 * lc - 1 : $urandom_range(0, 40);
      if (phase == 3) begin
        drain();
        hold_cycles = 400;
      end
      run_tree(lc, nc, wf, $urandom_range(10, 6 * lc + 10), phase % 4);
      phase++;
    end

    drain();
    idle_mode = 0;
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
